// ===== hw/rtl/wavetable_oscillator_envelope_defines.svh =====
// Assertion macros for the wavetable oscillator checker.
// Included by the checker file only; no other dependencies.
`ifndef WAVETABLE_OSCILLATOR_ENVELOPE_DEFINES_SVH
`define WAVETABLE_OSCILLATOR_ENVELOPE_DEFINES_SVH

// same-cycle implication
`define WTE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wte check failed");

// next-cycle implication
`define WTE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wte check failed");

`endif

// ===== hw/rtl/wte_pkg.sv =====
// Shared types and constants for the wavetable oscillator.
// No dependencies; used by wte_dp, the top level and the checker.
package wte_pkg;

	typedef enum logic [1:0] {
		ACT_TICK       = 2'd0,
		ACT_RESTART    = 2'd1,
		ACT_WR_ATTACK  = 2'd2,
		ACT_WR_SUSTAIN = 2'd3
	} action_t;

	localparam logic [2:0] CFG_PHASE_STEP   = 3'd0;
	localparam logic [2:0] CFG_ATTACK_LEN   = 3'd1;
	localparam logic [2:0] CFG_RAMP_STEP    = 3'd2;
	localparam logic [2:0] CFG_SUSTAIN_LVL  = 3'd3;
	localparam logic [2:0] CFG_CROSSFADE    = 3'd4;
	localparam logic [2:0] CFG_TOTAL_LEN    = 3'd5;

	localparam logic [23:0] RST_PHASE_STEP  = 24'd167394;
	localparam logic [23:0] RST_ATTACK_LEN  = 24'd4410;
	localparam logic [30:0] RST_RAMP_STEP   = 31'd486958;
	localparam logic [15:0] RST_SUSTAIN_LVL = 16'd22938;
	localparam logic [15:0] RST_CROSSFADE   = 16'd16384;
	localparam logic [31:0] RST_TOTAL_LEN   = 32'd52920;

	localparam logic [15:0] ONE_Q15 = 16'h8000;

	typedef struct packed {
		logic start;
		logic in_attack;
		logic ack;
	} dp_ctl_t;

endpackage

// ===== hw/rtl/wte_tables.sv =====
// Attack and sustain wave tables: one write port, registered reads.
// Depends on nothing beyond its parameter.
module wte_tables #(
	parameter int AW = 8
) (
	input  logic                 clk,
	input  logic                 wr_attack,
	input  logic                 wr_sustain,
	input  logic [AW-1:0]        wr_addr,
	input  logic signed [15:0]   wr_data,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	input  logic [AW-1:0]        rd_addr_nxt,
	output logic signed [15:0]   cur_attack,
	output logic signed [15:0]   nxt_attack,
	output logic signed [15:0]   cur_sustain
);

	logic signed [15:0] attack_mem  [2**AW];
	logic signed [15:0] sustain_mem [2**AW];

	always_ff @(posedge clk) begin
		if (wr_attack) begin
			attack_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			cur_attack <= attack_mem[rd_addr];
			nxt_attack <= attack_mem[rd_addr_nxt];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_sustain) begin
			sustain_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			cur_sustain <= sustain_mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/wte_dp.sv =====
// Sample datapath: envelope, crossfade mix, envelope scaling, rounding, saturation.
// Depends on wte_pkg; table words arrive in the cycle after start.
module wte_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  wte_pkg::dp_ctl_t    ctl,
	input  logic [23:0]         count_lo,
	input  logic [30:0]         ramp_step,
	input  logic [15:0]         sustain_level,
	input  logic [15:0]         crossfade,
	input  logic signed [15:0]  cur_attack,
	input  logic signed [15:0]  nxt_attack,
	input  logic signed [15:0]  cur_sustain,
	output logic                res_valid,
	output logic signed [15:0]  res_sample
);

	logic               v_s1, v_s2, v_s3, v_s4;
	logic               in_attack_s1;
	logic [15:0]        env_s1, env_s2, env_s3;
	logic signed [32:0] p_cur_s2, p_nxt_s2;
	logic signed [15:0] mix_s3;
	logic signed [32:0] prod_s4;

	logic [54:0]        env_prod;
	logic [38:0]        env_raw;
	logic [15:0]        env_next;
	logic [15:0]        cf;
	logic [15:0]        w_cur;
	logic signed [15:0] cur_sel;
	logic signed [33:0] mix_sum;
	logic signed [33:0] out_sum;
	logic signed [18:0] out_q;

	// envelope: linear ramp during attack, flat sustain after, both capped at 1.0
	assign env_prod = 55'(count_lo) * 55'(ramp_step);
	assign env_raw  = env_prod[54:16];
	always_comb begin
		if (ctl.in_attack) begin
			env_next = (env_raw > 39'(wte_pkg::ONE_Q15)) ? wte_pkg::ONE_Q15 : env_raw[15:0];
		end else begin
			env_next = (sustain_level > wte_pkg::ONE_Q15) ? wte_pkg::ONE_Q15 : sustain_level;
		end
	end

	assign cf      = (crossfade > wte_pkg::ONE_Q15) ? wte_pkg::ONE_Q15 : crossfade;
	assign w_cur   = 16'(17'h10000 - 17'(cf) - 17'h08000);
	assign cur_sel = in_attack_s1 ? cur_attack : cur_sustain;

	assign mix_sum = 34'(p_cur_s2) + 34'(p_nxt_s2) + 34'sd16384;
	assign out_sum = 34'(prod_s4) + 34'sd16384;
	assign out_q   = out_sum[33:15];

	always_comb begin
		if (out_q > 19'sd32767) begin
			res_sample = 16'sh7fff;
		end else if (out_q < -19'sd32768) begin
			res_sample = -16'sh8000;
		end else begin
			res_sample = out_q[15:0];
		end
	end

	assign res_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= ctl.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			// hold the finished word until the sequencer takes it
			if (v_s3) begin
				v_s4 <= 1'b1;
			end else if (ctl.ack) begin
				v_s4 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			env_s1       <= env_next;
			in_attack_s1 <= ctl.in_attack;
		end
		if (v_s1) begin
			p_cur_s2 <= $signed({1'b0, w_cur}) * cur_sel;
			p_nxt_s2 <= $signed({1'b0, cf}) * nxt_attack;
			env_s2   <= env_s1;
		end
		if (v_s2) begin
			mix_s3 <= mix_sum[30:15];
			env_s3 <= env_s2;
		end
		if (v_s3) begin
			prod_s4 <= mix_s3 * $signed({1'b0, env_s3});
		end
	end

endmodule

// ===== hw/rtl/wavetable_oscillator_envelope.sv =====
// Top level of the wavetable oscillator with attack envelope.
// Depends on wte_pkg, wte_tables and wte_dp.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_ready   action, table_address, table_word
//   out      source     out_valid / out_ready sample_out, playing
//   cfg      sink       cfg_wr_en             cfg_index, cfg_data
//
// A restart or table write leaves the input ready. A tick passes through table read,
// crossfade multiply, mix round, envelope multiply, then load into the output
// register; the in-flight tick blocks the input until its word reaches that register.
// The output register lets a new item enter while a finished word waits.
// Reset clears phase, sample count and handshakes and loads the config defaults; tables are not cleared.
module wavetable_oscillator_envelope #(
	parameter int TABLE_SIZE = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic [7:0]         table_address,
	input  logic signed [15:0] table_word,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample_out,
	output logic               playing,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int AW = $clog2(TABLE_SIZE);

	typedef enum logic {
		ST_IDLE,
		ST_BUSY
	} state_t;

	state_t state_q;

	logic [23:0] phase_step_q;
	logic [23:0] attack_len_q;
	logic [30:0] ramp_step_q;
	logic [15:0] sustain_lvl_q;
	logic [15:0] crossfade_q;
	logic [31:0] total_len_q;

	logic [23:0] phase_q;
	logic [31:0] count_q;
	logic        playing_pend_q;

	wte_pkg::action_t act;
	wte_pkg::dp_ctl_t dp_ctl;
	logic             accept;
	logic             tick;
	logic [31:0]      count_next;
	logic [15:0]      idx_wide;
	logic [15:0]      addr_wide;
	logic [AW-1:0]    rd_idx;
	logic [AW-1:0]    rd_nxt;
	logic [AW-1:0]    wr_addr;
	logic             res_valid;
	logic signed [15:0] res_sample;
	logic             load_out;
	logic signed [15:0] cur_attack, nxt_attack, cur_sustain;

	assign act      = wte_pkg::action_t'(action);
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign tick     = accept && (act == wte_pkg::ACT_TICK);

	assign idx_wide  = {8'd0, phase_q[23:16]};
	assign addr_wide = {8'd0, table_address};
	assign rd_idx    = idx_wide[AW-1:0];
	assign rd_nxt    = rd_idx + AW'(1);
	assign wr_addr   = addr_wide[AW-1:0];

	// saturate rather than wrap at the top of the counter
	assign count_next = (count_q == 32'hffff_ffff) ? count_q : count_q + 32'd1;

	assign load_out = (state_q == ST_BUSY) && res_valid && (!out_valid || out_ready);

	assign dp_ctl.start     = tick;
	assign dp_ctl.in_attack = count_q < {8'd0, attack_len_q};
	assign dp_ctl.ack       = load_out;

	wte_tables #(
		.AW (AW)
	) u_tables (
		.clk         (clk),
		.wr_attack   (accept && (act == wte_pkg::ACT_WR_ATTACK)),
		.wr_sustain  (accept && (act == wte_pkg::ACT_WR_SUSTAIN)),
		.wr_addr     (wr_addr),
		.wr_data     (table_word),
		.rd_en       (tick),
		.rd_addr     (rd_idx),
		.rd_addr_nxt (rd_nxt),
		.cur_attack  (cur_attack),
		.nxt_attack  (nxt_attack),
		.cur_sustain (cur_sustain)
	);

	wte_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (dp_ctl),
		.count_lo      (count_q[23:0]),
		.ramp_step     (ramp_step_q),
		.sustain_level (sustain_lvl_q),
		.crossfade     (crossfade_q),
		.cur_attack    (cur_attack),
		.nxt_attack    (nxt_attack),
		.cur_sustain   (cur_sustain),
		.res_valid     (res_valid),
		.res_sample    (res_sample)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q  <= wte_pkg::RST_PHASE_STEP;
			attack_len_q  <= wte_pkg::RST_ATTACK_LEN;
			ramp_step_q   <= wte_pkg::RST_RAMP_STEP;
			sustain_lvl_q <= wte_pkg::RST_SUSTAIN_LVL;
			crossfade_q   <= wte_pkg::RST_CROSSFADE;
			total_len_q   <= wte_pkg::RST_TOTAL_LEN;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				wte_pkg::CFG_PHASE_STEP:  phase_step_q  <= cfg_data[23:0];
				wte_pkg::CFG_ATTACK_LEN:  attack_len_q  <= cfg_data[23:0];
				wte_pkg::CFG_RAMP_STEP:   ramp_step_q   <= cfg_data[30:0];
				wte_pkg::CFG_SUSTAIN_LVL: sustain_lvl_q <= cfg_data[15:0];
				wte_pkg::CFG_CROSSFADE:   crossfade_q   <= cfg_data[15:0];
				wte_pkg::CFG_TOTAL_LEN:   total_len_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= 24'd0;
			count_q        <= 32'd0;
			playing_pend_q <= 1'b0;
		end else if (accept && (act == wte_pkg::ACT_RESTART)) begin
			phase_q <= 24'd0;
			count_q <= 32'd0;
		end else if (tick) begin
			// advance the voice now; the datapath works from the captured values
			phase_q        <= phase_q + phase_step_q;
			count_q        <= count_next;
			playing_pend_q <= count_next < total_len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			out_valid  <= 1'b0;
			sample_out <= 16'sd0;
			playing    <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (tick) begin
						state_q <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					if (load_out) begin
						out_valid  <= 1'b1;
						sample_out <= res_sample;
						playing    <= playing_pend_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/wte_chk.sv =====
// Port-level checker for the wavetable oscillator, bound to the top level.
// Depends on wte_pkg and the assertion macros header.
`include "wavetable_oscillator_envelope_defines.svh"

module wte_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [1:0]         action,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] sample_out,
	input logic               playing
);

	// a stalled output word holds
	`WTE_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(sample_out) && $stable(playing))

	// a tick blocks the input on the next cycle
	`WTE_ASSERT_NXT(a_tick_busy, clk, arst_n, in_valid && in_ready && action == wte_pkg::ACT_TICK, !in_ready)

	// restart and table writes leave the input open
	`WTE_ASSERT_NXT(a_ctrl_open, clk, arst_n, in_valid && in_ready && action != wte_pkg::ACT_TICK, in_ready)

	// a tick is later followed by a valid word on the output
	`WTE_ASSERT_IMP(a_tick_word, clk, arst_n, in_valid && in_ready && action == wte_pkg::ACT_TICK, ##5 out_valid)

endmodule

bind wavetable_oscillator_envelope wte_chk u_wte_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.action     (action),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.sample_out (sample_out),
	.playing    (playing)
);

// ===== dv/wavetable_oscillator_envelope_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the wavetable oscillator: loads both tables, then runs
// directed and random ticks, restarts and writes over several register settings
// and handshake patterns. Depends on wte_pkg and wavetable_oscillator_envelope.
module wavetable_oscillator_envelope_tb;
	import wte_pkg::*;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASES        = 8;
	localparam int RANDOM_ITEMS  = 140;
	localparam logic [2:0] CFG_UNUSED = 3'd7;

	typedef struct {
		logic signed [15:0] level;
		logic               active;
	} voice_out_t;

	class voice_scoreboard;
		logic signed [15:0] attack_mem [256];
		logic signed [15:0] sustain_mem [256];
		logic [23:0] phase_acc;
		logic [31:0] count;
		logic [23:0] step;
		logic [23:0] attack_len;
		logic [30:0] ramp;
		logic [15:0] sustain_lvl;
		logic [15:0] xfade;
		logic [31:0] total_len;
		voice_out_t  due_samples [$];
		int          errors;

		function new();
			phase_acc   = '0;
			count       = '0;
			step        = RST_PHASE_STEP;
			attack_len  = RST_ATTACK_LEN;
			ramp        = RST_RAMP_STEP;
			sustain_lvl = RST_SUSTAIN_LVL;
			xfade       = RST_CROSSFADE;
			total_len   = RST_TOTAL_LEN;
			errors      = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				CFG_PHASE_STEP:  step        = data[23:0];
				CFG_ATTACK_LEN:  attack_len  = data[23:0];
				CFG_RAMP_STEP:   ramp        = data[30:0];
				CFG_SUSTAIN_LVL: sustain_lvl = data[15:0];
				CFG_CROSSFADE:   xfade       = data[15:0];
				CFG_TOTAL_LEN:   total_len   = data;
				default: ;
			endcase
		endfunction

		// floor((v + 0.5 lsb) / 2^15), arithmetic shift keeps negatives right
		function longint q15_round(longint v);
			return (v + 64'sd16384) >>> 15;
		endfunction

		function voice_out_t next_sample();
			logic [7:0]      idx;
			logic [7:0]      nxt;
			bit              attacking;
			longint          one;
			longint          cur;
			longint          ahead;
			longint          cf;
			longint          mix;
			longint          env;
			longint          y;
			longint unsigned ramp_prod;
			voice_out_t      res;
			one       = longint'(ONE_Q15);
			idx       = phase_acc[23:16];
			nxt       = idx + 8'd1;
			attacking = count < {8'd0, attack_len};
			cur       = attacking ? longint'(attack_mem[idx]) : longint'(sustain_mem[idx]);
			ahead     = longint'(attack_mem[nxt]);
			cf        = (xfade > ONE_Q15) ? one : longint'(xfade);
			mix       = q15_round((one - cf) * cur + cf * ahead);
			if (attacking) begin
				ramp_prod = (64'(count) * 64'(ramp)) >> 16;
				env = (ramp_prod > 64'(ONE_Q15)) ? one : longint'(ramp_prod);
			end else begin
				env = (sustain_lvl > ONE_Q15) ? one : longint'(sustain_lvl);
			end
			y = q15_round(mix * env);
			if (y > 32767)
				y = 32767;
			if (y < -32768)
				y = -32768;
			phase_acc = phase_acc + step;
			// hold the counter at its ceiling rather than wrap
			if (count != 32'hFFFF_FFFF)
				count = count + 32'd1;
			res.level  = y[15:0];
			res.active = count < total_len;
			return res;
		endfunction

		function void note_word(action_t act, logic [7:0] addr, logic signed [15:0] word);
			case (act)
				ACT_RESTART: begin
					phase_acc = '0;
					count     = '0;
				end
				ACT_WR_ATTACK:  attack_mem[addr]  = word;
				ACT_WR_SUSTAIN: sustain_mem[addr] = word;
				default:        due_samples.push_back(next_sample());
			endcase
		endfunction

		function void check_word(logic signed [15:0] level, logic active);
			voice_out_t want;
			if (due_samples.size() == 0) begin
				$error("sample_out %0d arrived with no tick waiting", level);
				errors++;
				return;
			end
			want = due_samples.pop_front();
			if (level !== want.level) begin
				$error("sample_out expected %0d got %0d", want.level, level);
				errors++;
			end
			if (active !== want.active) begin
				$error("playing expected %0b got %0b", want.active, active);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         action;
	logic [7:0]         table_address;
	logic signed [15:0] table_word;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] sample_out;
	logic               playing;
	logic               cfg_wr_en;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;

	voice_scoreboard voice_sb;
	int              send_idle_pct;
	int              stall_pct;
	bit              hold_req;
	int              hold_left;
	int              cycles;

	wavetable_oscillator_envelope DUT (.*);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				voice_sb.note_word(action_t'(action), table_address, table_word);
			if (out_valid && out_ready)
				voice_sb.check_word(sample_out, playing);
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("wavetable_oscillator_envelope_tb failed");
		$finish;
	end

	// receiver: random back-pressure, or one long hold-off on request
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				hold_left = HOLD_CYCLES;
				while (hold_left > 0) begin
					@(posedge clk);
					hold_left--;
				end
				hold_req = 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic offer(input action_t act, input logic [7:0] addr, input logic [15:0] word);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		action        <= act;
		table_address <= addr;
		table_word    <= word;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		voice_sb.set_reg(idx, data);
	endtask

	task automatic program_voice(input int p);
		case (p)
			1: begin
				write_reg(CFG_PHASE_STEP, 32'h00FF_FFFF);
				write_reg(CFG_ATTACK_LEN, 32'd0);
				write_reg(CFG_RAMP_STEP, 32'd0);
				write_reg(CFG_SUSTAIN_LVL, 32'd0);
				write_reg(CFG_CROSSFADE, 32'd0);
				write_reg(CFG_TOTAL_LEN, 32'd0);
			end
			2: begin
				write_reg(CFG_PHASE_STEP, 32'h0001_0000);
				write_reg(CFG_ATTACK_LEN, 32'd1);
				write_reg(CFG_RAMP_STEP, 32'h7FFF_FFFF);
				write_reg(CFG_SUSTAIN_LVL, 32'h0000_FFFF);
				write_reg(CFG_CROSSFADE, 32'h0000_FFFF);
				write_reg(CFG_TOTAL_LEN, 32'hFFFF_FFFF);
			end
			3: begin
				write_reg(CFG_PHASE_STEP, $urandom);
				write_reg(CFG_ATTACK_LEN, 32'd40);
				write_reg(CFG_RAMP_STEP, 32'h0010_0000);
				write_reg(CFG_SUSTAIN_LVL, 32'd32768);
				write_reg(CFG_CROSSFADE, 32'd32768);
				write_reg(CFG_TOTAL_LEN, 32'd60);
			end
			4: begin
				write_reg(CFG_PHASE_STEP, 32'h0000_0100);
				write_reg(CFG_ATTACK_LEN, 32'h00FF_FFFF);
				write_reg(CFG_RAMP_STEP, 32'h7FFF_FFFF);
				write_reg(CFG_SUSTAIN_LVL, 32'd12345);
				write_reg(CFG_CROSSFADE, 32'd32767);
				write_reg(CFG_TOTAL_LEN, 32'd100);
			end
			default: begin
				// unused index must leave every register alone
				if (p == 5)
					write_reg(CFG_UNUSED, $urandom);
				write_reg(CFG_PHASE_STEP, $urandom);
				write_reg(CFG_ATTACK_LEN, $urandom_range(64, 1));
				write_reg(CFG_RAMP_STEP, $urandom);
				write_reg(CFG_SUSTAIN_LVL, $urandom_range(36000));
				write_reg(CFG_CROSSFADE, $urandom);
				write_reg(CFG_TOTAL_LEN, $urandom_range(300));
			end
		endcase
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_phase(input int p);
		int          r;
		action_t     act;
		logic [15:0] word;
		case (p % 4)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 79; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 79; end
			default: begin send_idle_pct = 6; stall_pct = 6; end
		endcase
		if (p == 0) begin
			// fill both tables so that no tick reads an unwritten entry
			for (int a = 0; a < 256; a++)
				offer(ACT_WR_ATTACK, 8'(a),
					(a == 0) ? 16'h8000 : (a == 1) ? 16'h7FFF : 16'($urandom));
			for (int a = 0; a < 256; a++)
				offer(ACT_WR_SUSTAIN, 8'(a),
					(a == 0) ? 16'h7FFF : (a == 1) ? 16'h8000 : 16'($urandom));
			offer(ACT_TICK, 8'd0, 16'h0000);
			offer(ACT_RESTART, 8'hFF, 16'hFFFF);
			repeat (3)
				offer(ACT_TICK, 8'hFF, 16'h8000);
			offer(ACT_WR_ATTACK, 8'hFF, 16'h7FFF);
			offer(ACT_WR_SUSTAIN, 8'hFF, 16'h8000);
			offer(ACT_WR_ATTACK, 8'h00, 16'h8000);
			repeat (3)
				offer(ACT_TICK, 8'h00, 16'h7FFF);
		end else begin
			program_voice(p);
		end
		if (p % 4 == 0)
			hold_req = 1'b1;
		offer(ACT_RESTART, 8'($urandom_range(255)), 16'($urandom));
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			r    = $urandom_range(99);
			word = 16'($urandom);
			if ($urandom_range(7) == 0)
				word = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
			if (r < 2)
				act = ACT_RESTART;
			else if (r < 10)
				act = ACT_WR_ATTACK;
			else if (r < 18)
				act = ACT_WR_SUSTAIN;
			else
				act = ACT_TICK;
			offer(act, 8'($urandom_range(255)), word);
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (voice_sb.due_samples.size() != 0)
			@(posedge clk);
		// let a trailing table write clear the pipe before registers change
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	initial begin
		voice_sb      = new();
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_req      = 1'b0;
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		action        <= ACT_TICK;
		table_address <= '0;
		table_word    <= '0;
		cfg_wr_en     <= 1'b0;
		cfg_index     <= CFG_PHASE_STEP;
		cfg_data      <= '0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < PHASES; p++)
			run_phase(p);
		if (voice_sb.errors == 0 && voice_sb.due_samples.size() == 0)
			$display("wavetable_oscillator_envelope_tb passed");
		else
			$display("wavetable_oscillator_envelope_tb failed");
		$finish;
	end

endmodule
